>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the line reader RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define MRLR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define MRLR_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mrlr_pkg.sv
package mrlr_pkg;

    // Operation codes of a request transfer
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Status codes of a response transfer
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TIMEOUT    = 3'd1;
    localparam logic [2:0] ST_DISCARD    = 3'd2;
    localparam logic [2:0] ST_DISCARD_TO = 3'd3;
    localparam logic [2:0] ST_UNEXPECTED = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_TEXT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN  = 3'd4;
    localparam int CFG_DATA_W = 64;

    // Register reset values
    localparam logic [15:0] TIMEOUT_RST  = 16'd500;
    localparam logic [5:0]  LIMIT_RST    = 6'd32;
    localparam logic [63:0] EXP_TEXT_RST = 64'h4B4F;
    localparam logic [3:0]  EXP_LEN_RST  = 4'd2;

    // Expected text holds at most this many characters
    localparam int          EXPECT_CHARS = 8;
    localparam logic [3:0]  EXP_LEN_MAX  = 4'(EXPECT_CHARS);

    // Line control characters
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;
        logic rd_cmp;
        logic rd_emit;
        logic cmp_adv;
        logic set_unexp;
        logic emit_load;
    } mrlr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic end_now;
        logic go_cmp;
        logic len_ok;
        logic byte_ok;
        logic cmp_last;
        logic emit_last;
        logic out_free;
        logic active;
    } mrlr_sts_t;

endpackage

>>> rtl/core/mrlr_req_if.sv
interface mrlr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

>>> rtl/core/mrlr_rsp_if.sv
interface mrlr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] line_char;
    logic       char_valid;
    logic [4:0] char_index;
    logic       last;

    modport source (
        output valid, output status, output line_char, output char_valid,
        output char_index, output last, input ready
    );
    modport sink (
        input valid, input status, input line_char, input char_valid,
        input char_index, input last, output ready
    );
endinterface

>>> rtl/core/modem_response_line_reader.sv
// Modem response line reader.
// request channel: operation (start, received byte, millisecond tick) and rx_byte.
// response channel: one transfer per stored character of a finished line, or one
// transfer with char_valid low for an empty line; all carry the final status and
// the last one has last set.
// Configuration: write cfg_data to register cfg_index while cfg_we is high.
// An item that does not end a read is taken; request.ready stays high.
// An item that ends a read drops request.ready while the line is played out:
// each character is read through the line store read port (S_EMIT_RD) and then
// loaded into the output slot (S_EMIT_LD); a compared line first reads and checks
// each expected character (S_CMP_ADDR, S_CMP_CHECK) before the first result.
// A stalled response holds the current result; the next character is read but
// not loaded until the slot frees. The last result may wait while new requests
// are taken.
// Reset clears the read state and output slot and loads the register defaults;
// the line store is not cleared.
module modem_response_line_reader
    import mrlr_pkg::*;
#(
    parameter int LINE_BYTES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mrlr_req_if.sink              request,
    mrlr_rsp_if.source            response,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    mrlr_cmd_t cmd;
    mrlr_sts_t sts;
    logic      in_ready;

    assign request.ready = in_ready;

    mrlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrlr_dpath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (request.operation),
        .rx_byte   (request.rx_byte),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (response)
    );

    `MRLR_ASSERT_IMPLY(a_busy_inactive, !in_ready, !sts.active,
        "read still open while line is played out")

endmodule

>>> rtl/core/mrlr_ctrl.sv
module mrlr_ctrl
    import mrlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mrlr_sts_t sts,
    output mrlr_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_CMP_ADDR  = 5'b00010,
        S_CMP_CHECK = 5'b00100,
        S_EMIT_RD   = 5'b01000,
        S_EMIT_LD   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence the compare and the character run
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && sts.end_now)
                begin
                    priority if (sts.go_cmp && sts.len_ok)
                    begin
                        state_next = S_CMP_ADDR;
                    end
                    else if (sts.go_cmp)
                    begin
                        cmd.set_unexp = 1'b1;
                        state_next    = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_CMP_ADDR:
            begin
                cmd.rd_cmp = 1'b1;
                state_next = S_CMP_CHECK;
            end
            S_CMP_CHECK:
            begin
                priority if (!sts.byte_ok)
                begin
                    cmd.set_unexp = 1'b1;
                    state_next    = S_EMIT_RD;
                end
                else if (sts.cmp_last)
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    cmd.cmp_adv = 1'b1;
                    state_next  = S_CMP_ADDR;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/mrlr_dpath.sv
module mrlr_dpath
    import mrlr_pkg::*;
#(
    parameter int LINE_BYTES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            operation,
    input  logic [7:0]            rx_byte,
    input  mrlr_cmd_t             cmd,
    output mrlr_sts_t             sts,
    mrlr_rsp_if.source            rsp
);

`include "assert_macros.svh"

    localparam int CNT_W   = $clog2(LINE_BYTES);
    localparam int LIM_W   = ($clog2(LINE_BYTES + 1) > 6) ? $clog2(LINE_BYTES + 1) : 6;
    localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(LINE_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_BYTES - 1);

    // Configuration registers
    logic [15:0] timeout_reg, timeout_next;
    logic [5:0]  limit_reg, limit_next;
    logic        cmp_en_reg, cmp_en_next;
    logic [63:0] exp_text_reg, exp_text_next;
    logic [3:0]  exp_len_reg, exp_len_next;

    // Read state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [15:0]      ticks_reg, ticks_next;
    logic             active_reg, active_next;
    logic [2:0]       status_reg, status_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [2:0]       cmp_idx_reg, cmp_idx_next;

    // Output slot
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_status_reg;
    logic [7:0]       out_char_reg;
    logic             out_cvalid_reg;
    logic [4:0]       out_index_reg;
    logic             out_last_reg;

    // Line store
    logic [7:0]       mem [LINE_BYTES];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] rd_addr;
    logic             mem_we;
    logic             mem_re;

    logic             is_start, is_byte, is_tick, is_lf, is_cr;
    logic [15:0]      ticks_inc;
    logic             lf_end, tick_end, start_end;
    logic [LIM_W-1:0] lim_sat, usable;
    logic             room;
    logic [3:0]       exp_n;
    logic             empty;

    // Decode the request
    assign is_start  = (operation == OP_START);
    assign is_byte   = (operation == OP_BYTE) && active_reg;
    assign is_tick   = (operation == OP_TICK) && active_reg;
    assign is_lf     = (rx_byte == CH_LF);
    assign is_cr     = (rx_byte == CH_CR);
    assign ticks_inc = ticks_reg + 16'd1;

    // Clamp the line limit to between 1 and the store size
    always_comb
    begin
        priority if (limit_reg == 6'd0)
        begin
            lim_sat = LIM_W'(1);
        end
        else if (LIM_W'(limit_reg) > LIM_MAX)
        begin
            lim_sat = LIM_MAX;
        end
        else
        begin
            lim_sat = LIM_W'(limit_reg);
        end
    end
    assign usable = lim_sat - LIM_W'(1);
    assign room   = LIM_W'(count_reg) < usable;

    assign exp_n = (exp_len_reg > EXP_LEN_MAX) ? EXP_LEN_MAX : exp_len_reg;
    assign empty = (count_reg == '0);

    // End conditions
    assign start_end = is_start && (timeout_reg == 16'd0);
    assign lf_end    = is_byte && is_lf && !empty;
    assign tick_end  = is_tick && (ticks_inc >= timeout_reg);

    // Status to the controller
    always_comb
    begin
        sts.end_now   = start_end || lf_end || tick_end;
        sts.go_cmp    = lf_end && !ovf_reg && cmp_en_reg;
        sts.len_ok    = (LIM_W'(count_reg) == LIM_W'(exp_n));
        sts.byte_ok   = (rd_data_reg == exp_text_reg[8*cmp_idx_reg +: 8]);
        sts.cmp_last  = ((4'(cmp_idx_reg) + 4'd1) == exp_n);
        sts.emit_last = empty || (({1'b0, k_reg} + 1'b1) == {1'b0, count_reg});
        sts.out_free  = !out_valid_reg || rsp.ready;
        sts.active    = active_reg;
    end

    // Store access
    assign mem_we  = cmd.take && is_byte && !is_lf && !is_cr && room;
    assign mem_re  = cmd.rd_cmp || cmd.rd_emit;
    assign rd_addr = cmd.rd_cmp ? CNT_W'(cmp_idx_reg) : k_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg] <= rx_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Configuration writes
    always_comb
    begin
        timeout_next  = timeout_reg;
        limit_next    = limit_reg;
        cmp_en_next   = cmp_en_reg;
        exp_text_next = exp_text_reg;
        exp_len_next  = exp_len_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:  timeout_next  = cfg_data[15:0];
                REG_LIMIT:    limit_next    = cfg_data[5:0];
                REG_CMP_EN:   cmp_en_next   = cfg_data[0];
                REG_EXP_TEXT: exp_text_next = cfg_data[63:0];
                REG_EXP_LEN:  exp_len_next  = cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // Advance the read on each transfer and command
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        ticks_next     = ticks_reg;
        active_next    = active_reg;
        status_next    = status_reg;
        k_next         = k_reg;
        cmp_idx_next   = cmp_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (cmd.take)
        begin
            k_next       = '0;
            cmp_idx_next = '0;
            priority if (is_start)
            begin
                count_next  = '0;
                ovf_next    = 1'b0;
                ticks_next  = 16'd0;
                active_next = !start_end;
                status_next = ST_TIMEOUT;
            end
            else if (lf_end)
            begin
                active_next = 1'b0;
                status_next = ovf_reg ? ST_DISCARD : ST_OK;
            end
            else if (is_byte && !is_lf && !is_cr)
            begin
                if (room)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (is_tick)
            begin
                ticks_next = ticks_inc;
                if (tick_end)
                begin
                    active_next = 1'b0;
                    status_next = ovf_reg ? ST_DISCARD_TO : ST_TIMEOUT;
                end
            end
            else
            begin
                count_next = count_reg;
            end
        end

        if (cmd.set_unexp)
        begin
            status_next = ST_UNEXPECTED;
        end
        if (cmd.cmp_adv)
        begin
            cmp_idx_next = cmp_idx_reg + 3'd1;
        end
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            k_next         = k_reg + 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            limit_reg     <= LIMIT_RST;
            cmp_en_reg    <= 1'b0;
            exp_text_reg  <= EXP_TEXT_RST;
            exp_len_reg   <= EXP_LEN_RST;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            ticks_reg     <= 16'd0;
            active_reg    <= 1'b0;
            status_reg    <= ST_OK;
            k_reg         <= '0;
            cmp_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            limit_reg     <= limit_next;
            cmp_en_reg    <= cmp_en_next;
            exp_text_reg  <= exp_text_next;
            exp_len_reg   <= exp_len_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            ticks_reg     <= ticks_next;
            active_reg    <= active_next;
            status_reg    <= status_next;
            k_reg         <= k_next;
            cmp_idx_reg   <= cmp_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output slot
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_status_reg <= status_reg;
            out_char_reg   <= empty ? 8'd0 : rd_data_reg;
            out_cvalid_reg <= !empty;
            out_index_reg  <= 5'(k_reg);
            out_last_reg   <= sts.emit_last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.line_char  = out_char_reg;
    assign rsp.char_valid = out_cvalid_reg;
    assign rsp.char_index = out_index_reg;
    assign rsp.last       = out_last_reg;

    `MRLR_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_LAST,
        "stored count beyond line store")
    `MRLR_ASSERT_IMPLY(a_load_free, cmd.emit_load, !out_valid_reg || rsp.ready,
        "output slot overwritten before transfer")
    `MRLR_ASSERT_IMPLY(a_empty_last, out_valid_reg && !out_cvalid_reg, out_last_reg,
        "empty line result not marked last")

endmodule
